// ===== hw/rtl/lww_pkg.sv =====
`timescale 1ns / 1ps
package lww_pkg;

  localparam int TableDepth = 1024;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int KeyBytes   = 8;
  localparam int CountW     = IdxW + 1;

  localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] FnvPrime = 64'h00000100000001b3;

  // load limit: 4*(live+1) > 3*depth
  localparam logic [CountW+1:0] LoadLimit = (CountW+2)'(3 * TableDepth);

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_GONE  = 2'd2
  } slot_state_t;

  typedef enum logic [2:0] {
    OP_SET     = 3'd0,
    OP_SET_LOC = 3'd1,
    OP_GET     = 3'd2,
    OP_DEL     = 3'd3,
    OP_DEL_LOC = 3'd4,
    OP_EXISTS  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_HASH,
    S_HASH_WAIT,
    S_PROBE,
    S_PROBE_WAIT,
    S_DECIDE,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] key;
    logic [63:0] data_value;
    logic [63:0] stamp_version;
    logic [63:0] stamp_time;
    logic [63:0] stamp_origin;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [63:0] read_value;
    logic [63:0] read_version;
    logic [63:0] read_stamp;
    logic [63:0] read_origin;
    logic [63:0] table_version;
  } rsp_t;

  // one slot entry in the payload memory
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
    logic [63:0] version;
    logic [63:0] ts;
    logic [63:0] origin;
  } entry_t;

  function automatic logic [63:0] cut_word(input logic [63:0] w, input int nbytes);
    logic [63:0] r;
    logic        stop;
    r = '0;
    stop = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (b >= nbytes || w[56-8*b +: 8] == 8'd0) stop = 1'b1;
      if (!stop) r[56-8*b +: 8] = w[56-8*b +: 8];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lww_hash.sv =====
`timescale 1ns / 1ps
// FNV-1a, one key byte per pass: xor then 64x64 multiply split into
// three 32x32 partial products over the following cycle.
module lww_hash (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [63:0]           key,
  output logic                  done,
  output logic [lww_pkg::IdxW-1:0] home
);
  import lww_pkg::*;

  logic [63:0] h;
  logic [63:0] kreg;
  logic [3:0]  cnt;
  logic        busy;
  logic        phase;
  logic [63:0] x;
  logic [63:0] p_ll;
  logic [63:0] p_lh;
  logic [63:0] p_hl;

  assign x = h ^ {56'd0, kreg[63:56]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= '0;
      end else if (busy) begin
        if (!phase) begin
          if (cnt == 4'd8 || kreg[63:56] == 8'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            phase <= 1'b1;
          end
        end else begin
          phase <= 1'b0;
          cnt   <= cnt + 4'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      h    <= FnvBasis;
      kreg <= key;
    end else if (busy) begin
      if (!phase) begin
        p_ll <= 64'(x[31:0]) * 64'(FnvPrime[31:0]);
        p_lh <= {32'd0, x[31:0] * FnvPrime[63:32]};
        p_hl <= {32'd0, x[63:32] * FnvPrime[31:0]};
      end else begin
        h    <= p_ll + {p_lh[31:0], 32'd0} + {p_hl[31:0], 32'd0};
        kreg <= {kreg[55:0], 8'd0};
      end
    end
  end

  assign home = h[IdxW-1:0];

endmodule

// ===== hw/rtl/lww_ctrl.sv =====
`timescale 1ns / 1ps
// Probe sequencer and slot memories (state codes and payload entries).
module lww_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_fire,
  input  lww_pkg::req_t   req_in,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output lww_pkg::rsp_t   rsp_out,
  output logic            hash_start,
  output logic [63:0]     hash_key,
  input  logic            hash_done,
  input  logic [lww_pkg::IdxW-1:0] hash_home
);
  import lww_pkg::*;

  fsm_t state, state_next;

  // slot memories
  logic [1:0] st_mem [TableDepth];
  entry_t     en_mem [TableDepth];
  logic [1:0] st_rd;
  entry_t     en_rd;
  logic       st_we;
  logic [IdxW-1:0] st_wa;
  logic [1:0] st_wd;
  logic       en_we;
  entry_t     en_wd;
  logic [IdxW-1:0] rd_addr;

  req_t            req;
  logic [63:0]     ver;
  logic [63:0]     org;
  logic [IdxW-1:0] idx;
  logic [IdxW:0]   step;
  logic [IdxW-1:0] clr_idx;
  logic [CountW-1:0] live;
  logic [63:0]     gver;
  rsp_t            rsp;
  rsp_t            rsp_next;

  logic is_set, is_del, found, newer, same, load_full;

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    st_rd <= st_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (en_we) en_mem[idx] <= en_wd;
    en_rd <= en_mem[rd_addr];
  end

  assign rd_addr = (state == S_HASH_WAIT) ? hash_home : idx;

  assign is_set = (req.op == OP_SET) || (req.op == OP_SET_LOC);
  assign is_del = (req.op == OP_DEL) || (req.op == OP_DEL_LOC);
  assign found  = (st_rd == SLOT_USED) && (en_rd.key == req.key);
  assign same   = (en_rd.version == ver) && (en_rd.ts == req.stamp_time)
                  && (en_rd.origin == org);
  assign newer  = (en_rd.version != ver) ? (en_rd.version > ver) :
                  (en_rd.ts != req.stamp_time) ? (en_rd.ts > req.stamp_time) :
                  (en_rd.origin > org);
  assign load_full = {live + CountW'(1), 2'b00} > LoadLimit;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:      if (clr_idx == IdxW'(TableDepth - 1)) state_next = S_IDLE;
      S_IDLE:       if (req_fire) state_next = S_HASH;
      S_HASH:       state_next = S_HASH_WAIT;
      S_HASH_WAIT:  if (hash_done) state_next = S_PROBE_WAIT;
      S_PROBE:      state_next = S_PROBE_WAIT;
      S_PROBE_WAIT: state_next = S_DECIDE;
      S_DECIDE: begin
        if (is_set && load_full) state_next = S_OUT;
        else if (st_rd != SLOT_EMPTY && !found && step <= (IdxW+1)'(TableDepth - 1))
          state_next = S_PROBE;
        else state_next = S_OUT;
      end
      S_OUT:        if (rsp_ready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // outputs; table_version follows the counter once the decide updates settle
  always_comb begin
    req_ready  = (state == S_IDLE);
    rsp_valid  = (state == S_OUT);
    hash_start = (state == S_HASH);
    hash_key   = req.key;
    rsp_out    = rsp;
    rsp_out.table_version = gver;
  end

  // clear and decide writes
  always_comb begin
    st_we = 1'b0;
    st_wa = idx;
    st_wd = SLOT_EMPTY;
    en_we = 1'b0;
    en_wd = '{key: req.key, value: req.data_value, version: ver,
              ts: req.stamp_time, origin: org};
    if (state == S_CLEAR) begin
      st_we = 1'b1;
      st_wa = clr_idx;
    end else if (state == S_DECIDE && !(st_rd != SLOT_EMPTY && !found &&
                 step <= (IdxW+1)'(TableDepth - 1))) begin
      if (is_set && !load_full) begin
        if (found) begin
          en_we = !(newer || same);
        end else if (st_rd == SLOT_EMPTY) begin
          en_we = 1'b1;
          st_we = 1'b1;
          st_wd = SLOT_USED;
        end
      end else if (is_del && found && !newer) begin
        st_we = 1'b1;
        st_wd = SLOT_GONE;
      end
    end
  end

  // result fields for the closing decide
  always_comb begin
    rsp_next = '0;
    rsp_next.status = ST_MISS;
    if (is_set) begin
      if (load_full) rsp_next.status = ST_FULL;
      else if (found) begin
        rsp_next.hit    = 1'b1;
        rsp_next.status = (newer || same) ? ST_STALE : ST_OK;
      end else rsp_next.status = (st_rd == SLOT_EMPTY) ? ST_OK : ST_FULL;
    end else if (found && (req.op == OP_GET || req.op == OP_EXISTS || is_del)) begin
      rsp_next.hit    = 1'b1;
      rsp_next.status = (is_del && newer) ? ST_STALE : ST_OK;
      if (req.op == OP_GET) begin
        rsp_next.read_value   = en_rd.value;
        rsp_next.read_version = en_rd.version;
        rsp_next.read_stamp   = en_rd.ts;
        rsp_next.read_origin  = en_rd.origin;
      end
    end
  end

  logic final_decide;
  assign final_decide = (state == S_DECIDE) && (state_next == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      live    <= '0;
      gver    <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + IdxW'(1);
      if (req_fire && (req_in.op == OP_SET_LOC || req_in.op == OP_DEL_LOC))
        gver <= gver + 64'd1;
      if (final_decide) begin
        if (is_set && !load_full) begin
          if (found ? !(newer || same) : (st_rd == SLOT_EMPTY)) begin
            if (ver > gver) gver <= ver;
            if (!found) live <= live + CountW'(1);
          end
        end else if (is_del) begin
          if (!(found && newer) && ver > gver) gver <= ver;
          if (found && !newer) live <= live - CountW'(1);
        end
      end
    end
  end

  // request capture, probe index, result
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req <= '{op: req_in.op, key: cut_word(req_in.key, KeyBytes),
               data_value: req_in.data_value, stamp_version: req_in.stamp_version,
               stamp_time: req_in.stamp_time,
               stamp_origin: cut_word(req_in.stamp_origin, 8)};
      if (req_in.op == OP_SET_LOC || req_in.op == OP_DEL_LOC) begin
        ver <= gver + 64'd1;
        org <= '0;
      end else begin
        ver <= req_in.stamp_version;
        org <= cut_word(req_in.stamp_origin, 8);
      end
    end
    if (state == S_HASH_WAIT && hash_done) begin
      idx  <= hash_home;
      step <= (IdxW+1)'(1);
    end
    if (state == S_DECIDE && state_next == S_PROBE) begin
      idx  <= idx + IdxW'(step * step);
      step <= step + (IdxW+1)'(1);
    end
    if (final_decide) rsp <= rsp_next;
  end

endmodule

// ===== hw/rtl/lww_hash_table.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Payload
// in      | to block  | lww_pkg::req_t  (in_valid / in_ready)
// out     | from block| lww_pkg::rsp_t  (out_valid / out_ready)
//
// One beat at a time: per key byte the hash does an xor with the
// partial products, then the sum of the split 64-bit multiply; the first
// probe passes a memory read wait and a decide state, and each further
// probe step a probe, a read wait and a decide state, before the result.
// After reset a clearing pass marks all TableDepth slots empty
// while in_ready stays low. out holds its beat until taken.
module lww_hash_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lww_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lww_pkg::rsp_t out_data
);
  import lww_pkg::*;

  logic            hash_start;
  logic            hash_done;
  logic [63:0]     hash_key;
  logic [IdxW-1:0] hash_home;

  lww_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (hash_key),
    .done  (hash_done),
    .home  (hash_home)
  );

  lww_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_fire   (in_valid && in_ready),
    .req_in     (in_data),
    .req_ready  (in_ready),
    .rsp_valid  (out_valid),
    .rsp_ready  (out_ready),
    .rsp_out    (out_data),
    .hash_start (hash_start),
    .hash_key   (hash_key),
    .hash_done  (hash_done),
    .hash_home  (hash_home)
  );

endmodule

// ===== hw/rtl/lww_checker.sv =====
`timescale 1ns / 1ps
module lww_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input lww_pkg::rsp_t out_data
);
  import lww_pkg::*;

  // one item in flight: no accept while a result waits
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept during result");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // a hit never reports not found or table full
  a_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |-> out_data.status == ST_OK || out_data.status == ST_STALE)
    else $error("hit with bad status");

  // accept leads to no immediate result
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");

endmodule

bind lww_hash_table lww_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
